/* hdl/xrr_pkg.sv */
`timescale 1ns / 1ps

package xrr_pkg;

	localparam logic [31:0] SEED_DEFAULT    = 32'h1234_5678;
	localparam int          XRR_QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_RAW   = 2'd0,
		OP_COIN  = 2'd1,
		OP_RANGE = 2'd2,
		OP_LOAD  = 2'd3
	} op_t;

	typedef struct packed {
		logic        [1:0]  operation;
		logic signed [31:0] low_bound;
		logic signed [31:0] span;
		logic        [31:0] state_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic        [31:0] state_after;
	} rsp_t;

	// Finished jobs go straight out; reduce jobs need the remainder unit.
	typedef enum logic {
		JOB_PASS = 1'b0,
		JOB_MOD  = 1'b1
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [31:0] num;          // final value, or the 31-bit draw to reduce
		logic [31:0] mag;          // divisor magnitude, 1 .. 2^31
		logic [31:0] low;
		logic [31:0] state_after;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} back_state_t;

	function automatic logic [31:0] xorshift_step(input logic [31:0] s);
		logic [31:0] x;
		x = s ^ (s << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

endpackage

/* hdl/xrr_front.sv */
`timescale 1ns / 1ps

module xrr_front import xrr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic push_valid,
	input  logic push_ready,
	output job_t push_job
);

	logic [31:0] gen_state_q;
	logic [31:0] adv;
	logic [31:0] next_state;
	logic [31:0] span_u;
	logic        take;

	assign req_ready  = push_ready;
	assign push_valid = req_valid;
	assign take       = req_valid && push_ready;
	assign adv        = xorshift_step(gen_state_q);
	assign span_u     = req.span;

	// Classify the request and resolve the generator state right away.
	always_comb begin
		push_job.kind        = JOB_PASS;
		push_job.num         = '0;
		push_job.mag         = '0;
		push_job.low         = req.low_bound;
		next_state           = adv;
		unique case (op_t'(req.operation))
			OP_RAW: begin
				push_job.num = {1'b0, adv[30:0]};
			end
			OP_COIN: begin
				push_job.num = {31'd0, ~adv[0]};
			end
			OP_RANGE: begin
				if (span_u == 32'd0) begin
					push_job.num = req.low_bound;
					next_state   = gen_state_q;
				end else begin
					push_job.kind = JOB_MOD;
					push_job.num  = {1'b0, adv[30:0]};
					push_job.mag  = span_u[31] ? (32'd0 - span_u) : span_u;
				end
			end
			OP_LOAD: begin
				next_state = (req.state_value == 32'd0) ? SEED_DEFAULT : req.state_value;
			end
			default: begin
				next_state = adv;
			end
		endcase
		push_job.state_after = next_state;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_state_q <= SEED_DEFAULT;
		end else if (take) begin
			gen_state_q <= next_state;
		end
	end

endmodule

/* hdl/xrr_fifo.sv */
`timescale 1ns / 1ps

module xrr_fifo import xrr_pkg::*; #(
	parameter int DEPTH = XRR_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop,
	output job_t pop_job
);

	localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_job    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/xrr_back.sv */
`timescale 1ns / 1ps

module xrr_back import xrr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop,
	input  job_t pop_job,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	back_state_t state_q;
	logic [31:0] rem_q;
	logic [30:0] dvd_q;
	logic [31:0] mag_q;
	logic [31:0] low_q;
	logic [31:0] sa_q;
	logic [4:0]  cnt_q;
	logic        out_valid_q;
	rsp_t        out_q;

	logic        out_free;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;
	logic [31:0] rem_next;
	logic        pass_load;
	logic        fin_load;

	assign out_free  = !out_valid_q || rsp_ready;
	assign pop       = (state_q == ST_IDLE) && pop_valid && out_free;
	assign pass_load = pop && (pop_job.kind == JOB_PASS);
	assign fin_load  = (state_q == ST_FIN) && out_free;

	// One restoring remainder step: shift in the next draw bit, subtract if it fits.
	assign trial    = {rem_q, dvd_q[30]};
	assign diff     = trial - {1'b0, mag_q};
	assign ge       = !diff[32];
	assign rem_next = ge ? diff[31:0] : trial[31:0];

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop && (pop_job.kind == JOB_MOD)) begin
						state_q <= ST_DIV;
						cnt_q   <= 5'd30;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 5'd0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (pass_load || fin_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q <= '0;
			dvd_q <= pop_job.num[30:0];
			mag_q <= pop_job.mag;
			low_q <= pop_job.low;
			sa_q  <= pop_job.state_after;
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[29:0], 1'b0};
		end
		if (pass_load) begin
			out_q.value       <= pop_job.num;
			out_q.state_after <= pop_job.state_after;
		end else if (fin_load) begin
			out_q.value       <= low_q + rem_q;
			out_q.state_after <= sa_q;
		end
	end

`ifndef SYNTHESIS
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE))
		else $error("job taken from queue while remainder unit busy");

	a_rem_below_mag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < mag_q))
		else $error("partial remainder not below divisor");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIV) && (cnt_q == 5'd0)) |=> (state_q == ST_FIN))
		else $error("remainder loop did not finish after last bit");

	a_fin_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && out_free) |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("finished remainder not moved to output register");
`endif

endmodule

/* hdl/xorshift32_ranged_random.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// -------  ---------  ---------------------  ---------------------------------------
// req      in         req_valid / req_ready  operation, low_bound, span, state_value
// rsp      out        rsp_valid / rsp_ready  value, state_after
//
// Timing: raw, coin, load and zero-span ranged beats go through the queue, then the output
// register, before rsp_valid rises; a ranged beat with nonzero span also passes the
// one-bit-per-cycle remainder loop (31 steps) over the 31-bit draw before the output register.
// Reset: arst_n clears the queue, the output register and loads the state 0x12345678.
// Stalls: the front keeps taking beats while the queue has room, even when the back
// is busy dividing or rsp is held; rsp_ready low holds the output beat in place.
module xorshift32_ranged_random import xrr_pkg::*; #(
	parameter int QUEUE_DEPTH = XRR_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// Front to queue.
	logic push_valid;
	logic push_ready;
	job_t push_job;

	// Queue to back.
	logic pop_valid;
	logic pop;
	job_t pop_job;

	// Front: hold the generator state, advance or load it on each accepted beat (a zero-span
	// ranged beat keeps it), and turn the request into a job (final value, or a draw to reduce).
	xrr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// Short job queue: decouple request intake from the remainder loop.
	xrr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_job    (pop_job)
	);

	// Back: pass finished jobs to the output register, or run the remainder loop
	// and add the low bound before delivering the beat.
	xrr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_job   (pop_job),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

// Checks xorshift32_ranged_random against a cycle-free shadow of the generator.
// The driver pulls request beats from a backlog, and the monitor matches every
// response beat with the oldest predicted draw. The run goes through several pacing
// phases: free flow, a mostly idle sender, a mostly stalled receiver, and light
// idling on both sides.
module tb;
	import xrr_pkg::*;

	// The slowest correct run stays far below this, even with an 85% receiver stall.
	localparam int CYCLE_LIMIT = 500000;
	// Tail wait at the end, longer than a nonzero-span ranged beat takes to complete.
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_PER_PHASE = 100;
	localparam int REPORT_LIMIT = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	req_t req_backlog[$];    // beats still to be offered to the block
	rsp_t draws_due[$];      // predicted responses, oldest first
	logic [31:0] gen_shadow = SEED_DEFAULT;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;
	int mismatch_count = 0;
	int draws_checked = 0;
	int op_count[4] = '{0, 0, 0, 0};

	// Per-phase pacing: free flow, idle sender, stalled receiver, light idling.
	int send_pace[4] = '{0, 85, 0, 7};
	int stall_pace[4] = '{0, 0, 85, 7};

	xorshift32_ranged_random uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Apply one request to the shadow generator and return the response it should give.
	function automatic rsp_t predict_draw(input req_t r);
		rsp_t        o;
		logic [31:0] x;
		logic [31:0] low31;
		logic [31:0] mag;
		logic [31:0] sum;
		logic        steps;
		o = '0;
		// Every draw advances the state, except a load and a ranged draw over zero span.
		steps = (r.operation != OP_LOAD) && !(r.operation == OP_RANGE && r.span == 0);
		if (steps) begin
			x = gen_shadow;
			x = x ^ (x << 13);
			x = x ^ (x >> 17);
			x = x ^ (x << 5);
			gen_shadow = x;
		end
		low31 = {1'b0, gen_shadow[30:0]};
		case (r.operation)
			OP_RAW: begin
				o.value = low31;
			end
			OP_COIN: begin
				o.value = {31'd0, ~low31[0]};
			end
			OP_RANGE: begin
				if (r.span == 0) begin
					o.value = r.low_bound;
				end else begin
					// Take the magnitude as unsigned; the most negative span gives 2^31.
					mag = r.span[31] ? (32'd0 - 32'(r.span)) : 32'(r.span);
					sum = 32'(r.low_bound) + (low31 % mag);
					o.value = sum;
				end
			end
			default: begin
				gen_shadow = (r.state_value == 0) ? SEED_DEFAULT : r.state_value;
				o.value = '0;
			end
		endcase
		o.state_after = gen_shadow;
		return o;
	endfunction

	function automatic req_t make_req(input op_t op, input logic [31:0] lo,
			input logic [31:0] sp, input logic [31:0] sv);
		req_t r;
		r.operation = op;
		r.low_bound = lo;
		r.span = sp;
		r.state_value = sv;
		return r;
	endfunction

	// Build a random beat; unused fields carry random junk the block must ignore.
	function automatic req_t random_req();
		int          pick;
		op_t         op;
		logic [31:0] lo;
		logic [31:0] sp;
		logic [31:0] sv;
		pick = $urandom_range(99);
		if (pick < 30) op = OP_RAW;
		else if (pick < 50) op = OP_COIN;
		else if (pick < 85) op = OP_RANGE;
		else op = OP_LOAD;

		case ($urandom_range(9))
			0: lo = 32'h7fff_ffff;
			1: lo = 32'h8000_0000;
			default: lo = $urandom;
		endcase

		case ($urandom_range(9))
			0: sp = '0;
			1: sp = 32'h8000_0000;
			2, 3, 4: sp = $urandom_range(1, 16);
			5, 6: sp = $urandom_range(1, 100000);
			default: sp = $urandom;
		endcase
		// Negate any span other than the most negative one half the time.
		if (sp != 32'h8000_0000 && $urandom_range(1)) sp = 32'd0 - sp;

		sv = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom);
		return make_req(op, lo, sp, sv);
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch on %0s at response %0d: expected %h, got %h",
				what, draws_checked, want, got);
	endtask

	// Driver: offer backlog beats, hold each one until accepted, and predict on accept.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				draws_due.push_back(predict_draw(req));
				op_count[req.operation]++;
			end
			// Load a new beat only when the slot is free or its beat was just taken.
			if (!req_valid || req_ready) begin
				if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted response beat, then decide whether to stall next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (draws_due.size() == 0) begin
					flag_mismatch("unexpected response value", '0, rsp.value);
				end else begin
					if (rsp.value !== draws_due[0].value)
						flag_mismatch("value", draws_due[0].value, rsp.value);
					if (rsp.state_after !== draws_due[0].state_after)
						flag_mismatch("state_after", draws_due[0].state_after,
							rsp.state_after);
					void'(draws_due.pop_front());
				end
				draws_checked++;
			end
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Wait until every queued beat went in and every predicted response came back.
	task automatic drain();
		@(negedge clk);
		while (req_backlog.size() != 0 || req_valid || draws_due.size() != 0)
			@(negedge clk);
	endtask

	// Stop a hung run.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d responses still due",
			cycle_count, draws_due.size());
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int ph;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats at free flow: field extremes, every operation, corner spans.
		req_backlog.push_back(make_req(OP_RAW, $urandom, $urandom, $urandom));
		req_backlog.push_back(make_req(OP_COIN, $urandom, $urandom, $urandom));
		req_backlog.push_back(make_req(OP_COIN, $urandom, $urandom, $urandom));
		req_backlog.push_back(make_req(OP_RAW, $urandom, $urandom, $urandom));
		// Zero span returns the low bound and holds the state.
		req_backlog.push_back(make_req(OP_RANGE, 32'h7fff_ffff, 32'd0, $urandom));
		req_backlog.push_back(make_req(OP_RANGE, 32'h8000_0000, 32'd0, $urandom));
		// Most negative span passes the 31-bit draw through.
		req_backlog.push_back(make_req(OP_RANGE, 32'd0, 32'h8000_0000, $urandom));
		// Largest span and bound force the sum to wrap.
		req_backlog.push_back(make_req(OP_RANGE, 32'h7fff_ffff, 32'h7fff_ffff, $urandom));
		req_backlog.push_back(make_req(OP_RANGE, $urandom, 32'hffff_ffff, $urandom));
		req_backlog.push_back(make_req(OP_RANGE, $urandom, 32'd1, $urandom));
		req_backlog.push_back(make_req(OP_RANGE, 32'h8000_0000, -32'sd7, $urandom));
		req_backlog.push_back(make_req(OP_RANGE, -32'sd5, 32'd10, $urandom));
		req_backlog.push_back(make_req(OP_RANGE, 32'h7fff_ffff, 32'h8000_0001, $urandom));
		// Loading zero falls back to the default seed.
		req_backlog.push_back(make_req(OP_LOAD, $urandom, $urandom, 32'd0));
		req_backlog.push_back(make_req(OP_RAW, $urandom, $urandom, $urandom));
		req_backlog.push_back(make_req(OP_LOAD, $urandom, $urandom, 32'hffff_ffff));
		req_backlog.push_back(make_req(OP_RAW, $urandom, $urandom, $urandom));
		req_backlog.push_back(make_req(OP_LOAD, $urandom, $urandom, 32'd1));
		req_backlog.push_back(make_req(OP_COIN, $urandom, $urandom, $urandom));
		req_backlog.push_back(make_req(OP_LOAD, $urandom, $urandom, 32'h8000_0000));
		req_backlog.push_back(make_req(OP_RAW, $urandom, $urandom, $urandom));
		req_backlog.push_back(make_req(OP_RANGE, 32'd0, 32'd0, $urandom));
		drain();

		// Random beats under each pacing mix.
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pace[ph];
			stall_pct = stall_pace[ph];
			repeat (RANDOM_PER_PHASE) req_backlog.push_back(random_req());
			drain();
		end

		send_idle_pct = 0;
		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d raw, %0d coin, %0d ranged and %0d load beats",
			op_count[OP_RAW], op_count[OP_COIN], op_count[OP_RANGE], op_count[OP_LOAD]);
		$display("checked %0d responses over four pacing mixes, %0d mismatches",
			draws_checked, mismatch_count);
		if (mismatch_count == 0 && draws_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
